### rtl/ple_pkg.sv
// package for the positional list engine: sizes, command codes, payload types
// no dependencies
package ple_pkg;
  localparam int Capacity = 64;
  localparam int DataWidth = 32;
  localparam int SlotW = $clog2(Capacity);
  localparam int CountW = $clog2(Capacity + 1);

  typedef enum logic [3:0] {
    CMD_INS_FIRST = 4'd0,
    CMD_INS_LAST  = 4'd1,
    CMD_INS_AT    = 4'd2,
    CMD_REM_FIRST = 4'd3,
    CMD_REM_LAST  = 4'd4,
    CMD_REM_AT    = 4'd5,
    CMD_RD_FIRST  = 4'd6,
    CMD_RD_LAST   = 4'd7,
    CMD_RD_AT     = 4'd8,
    CMD_SIZE      = 4'd9,
    CMD_CLEAR     = 4'd10
  } cmd_t;

  typedef struct packed {
    logic [3:0]  command;
    logic [6:0]  position;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [31:0] read_value;
    logic [6:0]  length;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture request, start at the head
    logic walk;       // follow one next link
    logic fetch;      // read payload and links of the target slot
    logic exec;       // main list update, capture result
    logic link;       // second link update of an insert before a slot, latch result
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic walk_done;
    logic need_walk;
  } sts_t;
endpackage

### rtl/ple_ram.sv
// generic ram with one write port and one registered read port
// no dependencies
module ple_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/ple_datapath.sv
// datapath: link and payload memories, head/tail/count, free stack, walk, result
// depends on ple_pkg, ple_ram
module ple_datapath (
  input  logic           clk,
  input  logic           rst,
  input  ple_pkg::req_t  req,
  input  ple_pkg::ctl_t  ctl,
  output ple_pkg::sts_t  sts,
  output ple_pkg::rsp_t  rsp
);
  localparam int SW = ple_pkg::SlotW;
  localparam int CW = ple_pkg::CountW;
  localparam int DW = ple_pkg::DataWidth;

  // list registers; hwm counts never-used slots handed out since the last clear,
  // fcnt counts freed slots waiting on the free stack
  logic [SW-1:0] head, tail;
  logic [CW-1:0] count;
  logic [CW-1:0] hwm;
  logic [CW-1:0] fcnt;
  logic [3:0]    cmd;
  logic [6:0]    pos;
  logic [DW-1:0] val;
  logic [SW-1:0] cur;
  logic [6:0]    step;
  logic          fail;
  logic [DW-1:0] rword;
  logic          relink;
  logic          at_head;
  logic [SW-1:0] sslot, pslot, nslot;

  // memory ports
  logic          pay_we, nxt_we, prv_we, fst_we;
  logic [SW-1:0] nxt_waddr, prv_waddr;
  logic [SW-1:0] nxt_wdata, prv_wdata;
  logic [SW-1:0] nxt_raddr, fst_raddr;
  logic [DW-1:0] pay_rdata;
  logic [SW-1:0] nxt_rdata, prv_rdata, fst_rdata;

  logic full, empty, pos_ok;
  logic [SW-1:0] nfree, tgt;

  ple_ram #(.Width(DW), .Depth(ple_pkg::Capacity)) u_store (
    .clk(clk), .we(pay_we), .waddr(nfree), .wdata(val), .raddr(tgt), .rdata(pay_rdata)
  );

  ple_ram #(.Width(SW), .Depth(ple_pkg::Capacity)) u_next (
    .clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata), .raddr(nxt_raddr),
    .rdata(nxt_rdata)
  );

  ple_ram #(.Width(SW), .Depth(ple_pkg::Capacity)) u_prev (
    .clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata), .raddr(tgt),
    .rdata(prv_rdata)
  );

  ple_ram #(.Width(SW), .Depth(ple_pkg::Capacity)) u_free (
    .clk(clk), .we(fst_we), .waddr(fcnt[SW-1:0]), .wdata(tgt), .raddr(fst_raddr),
    .rdata(fst_rdata)
  );

  assign full   = count >= CW'(ple_pkg::Capacity);
  assign empty  = count == '0;
  assign pos_ok = (pos != 7'd0) && (CW'(pos) <= count);

  // free slot: top of the free stack, else the next never-used slot
  assign fst_raddr = SW'(fcnt - CW'(1));
  assign nfree     = (fcnt != '0) ? fst_rdata : hwm[SW-1:0];

  // target slot of the command
  always_comb begin
    case (cmd)
      ple_pkg::CMD_INS_FIRST, ple_pkg::CMD_REM_FIRST, ple_pkg::CMD_RD_FIRST: tgt = head;
      ple_pkg::CMD_REM_LAST, ple_pkg::CMD_RD_LAST: tgt = tail;
      default: tgt = cur;
    endcase
  end

  logic okc;
  always_comb begin
    case (cmd)
      ple_pkg::CMD_INS_FIRST, ple_pkg::CMD_INS_LAST: okc = !full;
      ple_pkg::CMD_INS_AT: okc = !full && pos_ok;
      ple_pkg::CMD_REM_FIRST, ple_pkg::CMD_REM_LAST,
      ple_pkg::CMD_RD_FIRST, ple_pkg::CMD_RD_LAST, ple_pkg::CMD_CLEAR: okc = !empty;
      ple_pkg::CMD_REM_AT, ple_pkg::CMD_RD_AT: okc = pos_ok;
      ple_pkg::CMD_SIZE: okc = 1'b1;
      default: okc = 1'b0;
    endcase
  end

  logic is_ins, is_rem, is_rd, positional;
  assign is_ins = cmd inside {ple_pkg::CMD_INS_FIRST, ple_pkg::CMD_INS_LAST,
                              ple_pkg::CMD_INS_AT};
  assign is_rem = cmd inside {ple_pkg::CMD_REM_FIRST, ple_pkg::CMD_REM_LAST,
                              ple_pkg::CMD_REM_AT};
  assign is_rd  = cmd inside {ple_pkg::CMD_RD_FIRST, ple_pkg::CMD_RD_LAST,
                              ple_pkg::CMD_RD_AT};
  assign positional = cmd inside {ple_pkg::CMD_INS_AT, ple_pkg::CMD_REM_AT,
                                  ple_pkg::CMD_RD_AT};

  assign sts.need_walk = okc && positional;
  assign sts.walk_done = step >= pos;

  // next link read: chase the link just read while walking, else head or target
  assign nxt_raddr = ctl.walk ? nxt_rdata : (ctl.fetch ? tgt : head);

  // memory writes
  always_comb begin
    pay_we = 1'b0;
    fst_we = 1'b0;
    nxt_we = 1'b0; nxt_waddr = nfree; nxt_wdata = tgt;
    prv_we = 1'b0; prv_waddr = nfree; prv_wdata = prv_rdata;
    if (ctl.exec && okc) begin
      if (is_ins) begin
        pay_we = 1'b1;
        if (!empty) begin
          nxt_we = 1'b1;
          prv_we = 1'b1;
          if (cmd == ple_pkg::CMD_INS_LAST) begin
            nxt_waddr = tail; nxt_wdata = nfree; prv_wdata = tail;
          end
        end
      end
      if (is_rem) begin
        fst_we = 1'b1;
        nxt_we = tgt != head; nxt_waddr = prv_rdata; nxt_wdata = nxt_rdata;
        prv_we = tgt != tail; prv_waddr = nxt_rdata; prv_wdata = prv_rdata;
      end
    end else if (ctl.link && relink) begin
      nxt_we = !at_head; nxt_waddr = pslot; nxt_wdata = nslot;
      prv_we = 1'b1;     prv_waddr = sslot; prv_wdata = nslot;
    end
  end

  // request capture, walk and per-request captures
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd  <= req.command;
      pos  <= req.position;
      val  <= req.value[DW-1:0];
      step <= 7'd1;
      cur  <= head;
    end else if (ctl.walk) begin
      cur  <= nxt_rdata;
      step <= step + 7'd1;
    end
    if (ctl.exec) begin
      fail    <= !okc;
      rword   <= (okc && (is_rem || is_rd)) ? pay_rdata : '0;
      relink  <= okc && is_ins && !empty && (cmd != ple_pkg::CMD_INS_LAST);
      at_head <= tgt == head;
      sslot   <= tgt;
      pslot   <= prv_rdata;
      nslot   <= nfree;
    end
  end

  // head, tail, count and free bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0; tail <= '0; count <= '0; hwm <= '0; fcnt <= '0;
    end else if (ctl.exec && okc) begin
      if (is_ins) begin
        count <= count + CW'(1);
        if (fcnt != '0) fcnt <= fcnt - CW'(1);
        else hwm <= hwm + CW'(1);
        if (empty) begin
          head <= nfree; tail <= nfree;
        end else if (cmd == ple_pkg::CMD_INS_LAST) begin
          tail <= nfree;
        end else if (tgt == head) begin
          head <= nfree;
        end
      end
      if (is_rem) begin
        count <= count - CW'(1);
        fcnt  <= fcnt + CW'(1);
        if (tgt == head) head <= nxt_rdata;
        if (tgt == tail) tail <= prv_rdata;
      end
      if (cmd == ple_pkg::CMD_CLEAR) begin
        count <= '0; head <= '0; tail <= '0; hwm <= '0; fcnt <= '0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.link) begin
      rsp.status     <= fail;
      rsp.read_value <= 32'(rword);
      rsp.length     <= 7'(count);
    end
  end
endmodule

### rtl/ple_ctrl.sv
// controller state machine: sequences capture, walk, fetch, execute, link, result
// depends on ple_pkg
module ple_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  ple_pkg::sts_t sts,
  output ple_pkg::ctl_t ctl
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WALK  = 6'b000010,
    S_FETCH = 6'b000100,
    S_EXEC  = 6'b001000,
    S_LINK  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state, state_next;

  assign in_ready  = state == S_IDLE;
  assign out_valid = state == S_OUT;

  // next state and commands
  always_comb begin
    state_next = state;
    ctl = '0;
    case (state)
      S_IDLE: begin
        ctl.load = in_valid;
        if (in_valid) state_next = S_WALK;
      end
      S_WALK: begin
        if (sts.need_walk && !sts.walk_done) ctl.walk = 1'b1;
        else state_next = S_FETCH;
      end
      S_FETCH: begin
        ctl.fetch = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        ctl.exec = 1'b1;
        state_next = S_LINK;
      end
      S_LINK: begin
        ctl.link = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule

### rtl/positional_list_engine.sv
// positional list engine top level: controller plus datapath
// a request passes the walk, fetch, execute and link states before the result is
// valid; positional commands walk the next links to their target; one request is
// in flight at a time, and a new one is accepted once the result is taken
// synchronous active-high reset empties the list; memories need no clearing pass
module positional_list_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ple_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ple_pkg::rsp_t out_data
);
  ple_pkg::ctl_t ctl;
  ple_pkg::sts_t sts;

  ple_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .ctl(ctl)
  );

  ple_datapath u_dp (
    .clk(clk), .rst(rst), .req(in_data), .ctl(ctl), .sts(sts), .rsp(out_data)
  );
endmodule

### rtl/ple_checker.sv
// port-level checker for the positional list engine, bound to the top level
// depends on ple_pkg
module ple_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input ple_pkg::rsp_t out_data
);
  // one request in flight: no accept while a result is pending
  a_one: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("accept during result");
  // accepted request is never answered in the next cycle
  a_lat: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");
  // failures carry zero read data
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status) |-> out_data.read_value == 32'd0)
    else $error("nonzero data on failure");
  // length never exceeds capacity
  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.length <= 7'(ple_pkg::Capacity)) else $error("length");
  // result holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_data)) else $error("hold");
endmodule

bind positional_list_engine ple_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

### tb/positional_list_engine_tb.sv
// testbench for the positional list engine: directed and random list commands
// checked against an in-bench linked-list predictor; depends on ple_pkg and the rtl
module positional_list_engine_tb;
  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  ple_pkg::req_t in_data;
  logic out_valid;
  logic out_ready;
  ple_pkg::rsp_t out_data;

  // handshake idling in percent, and a long receiver hold-off
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_cycles;
  int unsigned fail_count;
  ple_pkg::rsp_t expected_rsps[$];

  // predictor state: list contents in order, head first
  logic [31:0] list_words[$];

  positional_list_engine i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // time limit: about 1900 items, stalls included
  initial begin
    #20000000;
    $display("positional_list_engine test failed");
    $finish;
  end

  // compute the response of one request and update the list
  function automatic ple_pkg::rsp_t predict_list_op(ple_pkg::req_t rq);
    ple_pkg::rsp_t r;
    int unsigned n;
    int unsigned p;
    n = list_words.size();
    p = rq.position;
    r.status = 1'b1;
    r.read_value = '0;
    case (rq.command)
      ple_pkg::CMD_INS_FIRST: if (n < ple_pkg::Capacity) begin
        list_words.push_front(rq.value);
        r.status = 1'b0;
      end
      ple_pkg::CMD_INS_LAST: if (n < ple_pkg::Capacity) begin
        list_words.push_back(rq.value);
        r.status = 1'b0;
      end
      ple_pkg::CMD_INS_AT: if (n < ple_pkg::Capacity && p >= 1 && p <= n) begin
        list_words.insert(p - 1, rq.value);
        r.status = 1'b0;
      end
      ple_pkg::CMD_REM_FIRST: if (n > 0) begin
        r.read_value = list_words.pop_front();
        r.status = 1'b0;
      end
      ple_pkg::CMD_REM_LAST: if (n > 0) begin
        r.read_value = list_words.pop_back();
        r.status = 1'b0;
      end
      ple_pkg::CMD_REM_AT: if (p >= 1 && p <= n) begin
        r.read_value = list_words[p - 1];
        list_words.delete(p - 1);
        r.status = 1'b0;
      end
      ple_pkg::CMD_RD_FIRST: if (n > 0) begin
        r.read_value = list_words[0];
        r.status = 1'b0;
      end
      ple_pkg::CMD_RD_LAST: if (n > 0) begin
        r.read_value = list_words[n - 1];
        r.status = 1'b0;
      end
      ple_pkg::CMD_RD_AT: if (p >= 1 && p <= n) begin
        r.read_value = list_words[p - 1];
        r.status = 1'b0;
      end
      ple_pkg::CMD_SIZE: r.status = 1'b0;
      ple_pkg::CMD_CLEAR: if (n > 0) begin
        list_words.delete();
        r.status = 1'b0;
      end
      default: ;
    endcase
    r.length = 7'(list_words.size());
    return r;
  endfunction

  // send one request, with random idle before it; valid stays up until the
  // next request or an idle cycle replaces it
  task automatic send_request(logic [3:0] cmd, logic [6:0] pos, logic [31:0] val);
    ple_pkg::req_t rq;
    rq.command = cmd;
    rq.position = pos;
    rq.value = val;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= rq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_rsps.push_back(predict_list_op(rq));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  // receiver stall pattern and long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // compare each accepted response with the oldest expectation
  always @(posedge clk) begin
    ple_pkg::rsp_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected response %p", out_data);
        fail_count++;
      end else begin
        e = expected_rsps.pop_front();
        if (out_data.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_data.status);
          fail_count++;
        end
        if (out_data.read_value !== e.read_value) begin
          $error("read_value expected %h actual %h", e.read_value, out_data.read_value);
          fail_count++;
        end
        if (out_data.length !== e.length) begin
          $error("length expected %0d actual %0d", e.length, out_data.length);
          fail_count++;
        end
      end
    end
  end

  // position biased toward the valid range, sometimes out of range
  function automatic logic [6:0] pick_position();
    int unsigned n;
    n = list_words.size();
    if ($urandom_range(9) == 0) return 7'($urandom_range(127));
    if (n == 0) return 7'($urandom_range(2));
    return 7'($urandom_range(n + 1));
  endfunction

  // edge cases: empty list, extreme fields, every command, unknown codes
  task automatic test_directed();
    send_request(ple_pkg::CMD_REM_FIRST, 0, 0);
    send_request(ple_pkg::CMD_RD_AT, 1, 0);
    send_request(ple_pkg::CMD_INS_AT, 1, 32'h1);
    send_request(ple_pkg::CMD_CLEAR, 0, 0);
    send_request(ple_pkg::CMD_INS_FIRST, 0, 32'hFFFF_FFFF);
    send_request(ple_pkg::CMD_INS_AT, 1, 32'h0);
    send_request(ple_pkg::CMD_INS_LAST, 127, 32'hA5A5_5A5A);
    send_request(ple_pkg::CMD_INS_AT, 3, 32'h5A5A_A5A5);
    send_request(ple_pkg::CMD_INS_AT, 5, 32'h1234);
    send_request(ple_pkg::CMD_RD_FIRST, 0, 0);
    send_request(ple_pkg::CMD_RD_LAST, 0, 0);
    send_request(ple_pkg::CMD_RD_AT, 2, 0);
    send_request(ple_pkg::CMD_RD_AT, 0, 0);
    send_request(ple_pkg::CMD_REM_AT, 2, 0);
    send_request(ple_pkg::CMD_REM_LAST, 0, 0);
    send_request(ple_pkg::CMD_SIZE, 0, 0);
    send_request(4'd11, 1, 0);
    send_request(4'd15, 127, 32'hFFFF_FFFF);
    send_request(ple_pkg::CMD_CLEAR, 0, 0);
    send_request(ple_pkg::CMD_SIZE, 0, 0);
    wait_drained();
  endtask

  // fill to capacity, fail on full, walk the deepest position
  task automatic test_full_store();
    repeat (ple_pkg::Capacity) send_request(ple_pkg::CMD_INS_LAST, 0, $urandom());
    send_request(ple_pkg::CMD_INS_FIRST, 0, 32'hDEAD);
    send_request(ple_pkg::CMD_INS_AT, 1, 32'hBEEF);
    send_request(ple_pkg::CMD_RD_AT, 64, 0);
    send_request(ple_pkg::CMD_REM_AT, 64, 0);
    send_request(ple_pkg::CMD_RD_AT, 65, 0);
    send_request(ple_pkg::CMD_CLEAR, 0, 0);
    wait_drained();
  endtask

  // receiver holds off while requests keep coming
  task automatic test_backpressure();
    hold_cycles <= 400;
    repeat (30) send_request(ple_pkg::CMD_INS_AT, 1, $urandom());
    wait_drained();
  endtask

  // random mix, weighted toward inserts while the list is shorter than 48 entries
  task automatic test_random(int unsigned count);
    int unsigned k;
    int unsigned sel;
    logic [3:0] cmd;
    for (k = 0; k < count; k++) begin
      sel = $urandom_range(99);
      if (sel < 2) cmd = 4'($urandom_range(15, 11));
      else if (sel < 4) cmd = ple_pkg::CMD_CLEAR;
      else if (sel < 40 && list_words.size() < 48) cmd = 4'($urandom_range(2));
      else cmd = 4'($urandom_range(9));
      send_request(cmd, pick_position(), $urandom());
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    fail_count = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_store();
    test_backpressure();
    test_random(400);
    send_idle_pct = 46;
    test_random(400);
    send_idle_pct = 0;
    recv_stall_pct = 46;
    test_random(400);
    send_idle_pct = 20;
    recv_stall_pct = 20;
    test_random(400);
    // sender pauses until everything has arrived
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(200);
    wait_drained();
    if (fail_count == 0) begin
      $display("positional_list_engine test passed");
    end else begin
      $display("positional_list_engine test failed");
    end
    $finish;
  end
endmodule
